[rtl/core/jsu_pkg.sv]
// jsu_pkg: item types, status codes, decoder state and helpers for the
// json string unescaper; used by jsu_decode and json_string_unescape_utf8.
// no dependencies.
package jsu_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       source_end;
    } src_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       last;
    } res_item_t;

    localparam logic [2:0] ST_DATA   = 3'd0;
    localparam logic [2:0] ST_END    = 3'd1;
    localparam logic [2:0] ST_CTRL   = 3'd2;
    localparam logic [2:0] ST_BADESC = 3'd3;
    localparam logic [2:0] ST_BADHEX = 3'd4;
    localparam logic [2:0] ST_UNTERM = 3'd5;
    localparam logic [2:0] ST_ESCEND = 3'd6;

    localparam int MaxResults = 3;

    typedef enum logic [2:0] {
        MODE_BODY = 3'b001,
        MODE_ESC  = 3'b010,
        MODE_HEX  = 3'b100
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [1:0]  hex_seen;
        logic [11:0] code;
    } dec_state_t;

    typedef struct packed {
        logic [1:0]                     count;
        res_item_t [MaxResults-1:0]     res;
        dec_state_t                     state;
    } dec_out_t;

    // bit 4 set when the byte is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            v = {1'b0, c[3:0] + 4'd9};
        return v;
    endfunction

endpackage

[rtl/core/jsu_decode.sv]
// jsu_decode: one source item against the current decoder state gives
// up to three result items and the next state. uses jsu_pkg.
module jsu_decode (
    input  jsu_pkg::src_item_t  item,
    input  jsu_pkg::dec_state_t state,
    output jsu_pkg::dec_out_t   dec
);
    import jsu_pkg::*;

    localparam dec_state_t StateClear = '{mode: MODE_BODY, hex_seen: 2'd0, code: 12'd0};

    logic [4:0]  hv;
    logic [15:0] code;

    assign hv   = hex_value(item.in_byte);
    assign code = {state.code, hv[3:0]};

    function automatic res_item_t mk(input logic [7:0] b, input logic [2:0] st,
                                     input logic l);
        res_item_t r;
        r.out_byte = b;
        r.status   = st;
        r.last     = l;
        return r;
    endfunction

    always_comb
    begin
        dec.count = 2'd1;
        dec.res   = '0;
        dec.state = StateClear;
        if (item.source_end)
        begin
            if (state.mode == MODE_ESC || state.mode == MODE_HEX)
                dec.res[0] = mk(8'h00, ST_ESCEND, 1'b1);
            else
                dec.res[0] = mk(8'h00, ST_UNTERM, 1'b1);
        end
        else
        begin
            unique case (state.mode)
                MODE_ESC:
                begin
                    case (item.in_byte)
                        8'h22, 8'h5C, 8'h2F: dec.res[0] = mk(item.in_byte, ST_DATA, 1'b1);
                        8'h62: dec.res[0] = mk(8'h08, ST_DATA, 1'b1);
                        8'h66: dec.res[0] = mk(8'h0C, ST_DATA, 1'b1);
                        8'h6E: dec.res[0] = mk(8'h0A, ST_DATA, 1'b1);
                        8'h72: dec.res[0] = mk(8'h0D, ST_DATA, 1'b1);
                        8'h74: dec.res[0] = mk(8'h09, ST_DATA, 1'b1);
                        8'h75:
                        begin
                            dec.count      = 2'd0;
                            dec.state.mode = MODE_HEX;
                        end
                        default: dec.res[0] = mk(8'h00, ST_BADESC, 1'b1);
                    endcase
                end
                MODE_HEX:
                begin
                    if (hv[4])
                        dec.res[0] = mk(8'h00, ST_BADHEX, 1'b1);
                    else if (state.hex_seen != 2'd3)
                    begin
                        dec.count          = 2'd0;
                        dec.state.mode     = MODE_HEX;
                        dec.state.hex_seen = state.hex_seen + 2'd1;
                        dec.state.code     = code[11:0];
                    end
                    else if (code <= 16'h007F)
                        dec.res[0] = mk(code[7:0], ST_DATA, 1'b1);
                    else if (code <= 16'h07FF)
                    begin
                        dec.count  = 2'd2;
                        dec.res[0] = mk(8'hC0 | {3'b000, code[10:6]}, ST_DATA, 1'b0);
                        dec.res[1] = mk(8'h80 | {2'b00, code[5:0]}, ST_DATA, 1'b1);
                    end
                    else
                    begin
                        dec.count  = 2'd3;
                        dec.res[0] = mk(8'hE0 | {4'h0, code[15:12]}, ST_DATA, 1'b0);
                        dec.res[1] = mk(8'h80 | {2'b00, code[11:6]}, ST_DATA, 1'b0);
                        dec.res[2] = mk(8'h80 | {2'b00, code[5:0]}, ST_DATA, 1'b1);
                    end
                end
                default:
                begin
                    if (item.in_byte == 8'h22)
                        dec.res[0] = mk(8'h00, ST_END, 1'b1);
                    else if (item.in_byte < 8'h20)
                        dec.res[0] = mk(8'h00, ST_CTRL, 1'b1);
                    else if (item.in_byte == 8'h5C)
                    begin
                        dec.count      = 2'd0;
                        dec.state.mode = MODE_ESC;
                    end
                    else
                        dec.res[0] = mk(item.in_byte, ST_DATA, 1'b1);
                end
            endcase
        end
    end

endmodule

[rtl/core/json_string_unescape_utf8.sv]
// json_string_unescape_utf8: top level of the json string unescaper with
// utf-8 output. uses jsu_pkg and jsu_decode.
//
// usage
//   src channel: one source item per accepted handshake, a string body
//   byte or a source-end marker. res channel: result items (decoded byte
//   or a status code), last set on the final item caused by one source item.
//   both channels move an item at an edge where valid is high and stall low.
// decode and flow
//   an item is decoded in the cycle it is accepted and its first result
//   shows on res in the next cycle. one source item per cycle is taken while
//   each gives at most one result and res is not stalled; a \u escape that
//   ends in two or three utf-8 bytes holds src until the single result port
//   has drained the three-entry result buffer. backslash and hex digits give
//   no result and do not hold src.
// reset
//   rst_n low clears the decoder to the string body state and empties the
//   result buffer.
// stall
//   while res is stalled the buffered results hold; src is stalled until
//   the last buffered result is taken, and may be taken in that same cycle.
module json_string_unescape_utf8 (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  jsu_pkg::src_item_t  src_item,
    output logic                res_valid,
    input  logic                res_stall,
    output jsu_pkg::res_item_t  res_item
);
    import jsu_pkg::*;

    dec_state_t                 state_reg, state_next;
    logic [1:0]                 cnt_reg, cnt_next;
    res_item_t [MaxResults-1:0] buf_reg, buf_next;
    dec_out_t                   dec;
    logic                       take, accept;

    jsu_decode u_decode (
        .item  (src_item),
        .state (state_reg),
        .dec   (dec)
    );

    assign res_valid = (cnt_reg != 2'd0);
    assign res_item  = buf_reg[0];
    assign take      = res_valid && !res_stall;
    assign src_stall = res_valid && !(take && cnt_reg == 2'd1);
    assign accept    = src_valid && !src_stall;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        buf_next   = buf_reg;
        if (accept)
        begin
            state_next = dec.state;
            cnt_next   = dec.count;
            buf_next   = dec.res;
        end
        else if (take)
        begin
            // shift the next buffered item to the head
            cnt_next = cnt_reg - 2'd1;
            buf_next = {res_item_t'('0), buf_reg[MaxResults-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{mode: MODE_BODY, hex_seen: 2'd0, code: 12'd0};
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> res_valid)
        else $error("src stalled with an empty result buffer");

    a_last_at_tail: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.last |-> cnt_reg == 2'd1)
        else $error("last item is not the final buffered result");

    a_not_last_has_more: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.last |-> cnt_reg > 2'd1)
        else $error("result without last has nothing after it");

    a_drain_continues: assert property (@(posedge clk) disable iff (!rst_n)
        take && cnt_reg > 2'd1 |=> res_valid)
        else $error("buffered results lost while draining");

    a_error_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && dec.count == 2'd1 && dec.res[0].status != ST_DATA
        |=> state_reg.mode == MODE_BODY && state_reg.hex_seen == 2'd0)
        else $error("decoder state not cleared after end or error");

endmodule

[verif/tb_json_string_unescape_utf8.sv]
`timescale 1ns / 100ps
// tb_json_string_unescape_utf8: self-checking bench for the json string unescaper.
// depends on jsu_pkg and json_string_unescape_utf8; no files, no arguments.
module tb_json_string_unescape_utf8;
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] BYTE_BS   = 8'h08;
    localparam logic [7:0] BYTE_FF   = 8'h0C;
    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] BYTE_CR   = 8'h0D;
    localparam logic [7:0] BYTE_TAB  = 8'h09;
    localparam int         PHASE_ITEMS = 85;
    localparam int         MAX_PRINTED = 200;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       src_valid = 1'b0;
    logic       src_stall;
    src_item_t  src_item = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    res_item_t  res_item;

    src_item_t  src_backlog[$];
    res_item_t  pending_results[$];
    int         send_idle_pct = 0;
    int         res_stall_pct = 0;
    int         items_added = 0;
    int         err_count = 0;

    // predicted decoder state
    mode_t       dec_mode = MODE_BODY;
    logic [1:0]  hex_cnt = '0;
    logic [11:0] code_acc = '0;

    json_string_unescape_utf8 u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    always #6 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return {1'b0, 4'(c - 8'h30)};
        if (c >= 8'h61 && c <= 8'h66)
            return {1'b0, 4'(c - 8'h61 + 8'd10)};
        if (c >= 8'h41 && c <= 8'h46)
            return {1'b0, 4'(c - 8'h41 + 8'd10)};
        return 5'h10;
    endfunction

    function automatic void push_result(input logic [7:0] b, input logic [2:0] st,
                                        input logic lst);
        res_item_t r;
        r.out_byte = b;
        r.status   = st;
        r.last     = lst;
        pending_results.insert(pending_results.size(), r);
    endfunction

    // end and error results return the decoder to the body state
    function automatic void fail_result(input logic [2:0] st);
        dec_mode = MODE_BODY;
        hex_cnt  = '0;
        code_acc = '0;
        push_result(8'h00, st, 1'b1);
    endfunction

    function automatic void escape_done(input logic [7:0] b);
        dec_mode = MODE_BODY;
        push_result(b, ST_DATA, 1'b1);
    endfunction

    function automatic void predict_unescape(input src_item_t it);
        logic [4:0]  nib;
        logic [15:0] cp;
        if (it.source_end) begin
            if (dec_mode == MODE_ESC || dec_mode == MODE_HEX)
                fail_result(ST_ESCEND);
            else
                fail_result(ST_UNTERM);
        end else if (dec_mode == MODE_ESC) begin
            case (it.in_byte)
                CH_QUOTE, CH_BSLASH, CH_SLASH: escape_done(it.in_byte);
                CH_B: escape_done(BYTE_BS);
                CH_F: escape_done(BYTE_FF);
                CH_N: escape_done(BYTE_LF);
                CH_R: escape_done(BYTE_CR);
                CH_T: escape_done(BYTE_TAB);
                CH_U:
                begin
                    dec_mode = MODE_HEX;
                    hex_cnt  = '0;
                    code_acc = '0;
                end
                default: fail_result(ST_BADESC);
            endcase
        end else if (dec_mode == MODE_HEX) begin
            nib = hex_nibble(it.in_byte);
            if (nib[4]) begin
                fail_result(ST_BADHEX);
            end else if (hex_cnt != 2'd3) begin
                code_acc = {code_acc[7:0], nib[3:0]};
                hex_cnt  = hex_cnt + 2'd1;
            end else begin
                cp       = {code_acc, nib[3:0]};
                dec_mode = MODE_BODY;
                hex_cnt  = '0;
                code_acc = '0;
                if (cp <= 16'h007F) begin
                    push_result(cp[7:0], ST_DATA, 1'b1);
                end else if (cp <= 16'h07FF) begin
                    push_result({3'b110, cp[10:6]}, ST_DATA, 1'b0);
                    push_result({2'b10, cp[5:0]}, ST_DATA, 1'b1);
                end else begin
                    // surrogates fall here too, unpaired
                    push_result({4'b1110, cp[15:12]}, ST_DATA, 1'b0);
                    push_result({2'b10, cp[11:6]}, ST_DATA, 1'b0);
                    push_result({2'b10, cp[5:0]}, ST_DATA, 1'b1);
                end
            end
        end else begin
            if (it.in_byte == CH_QUOTE) begin
                fail_result(ST_END);
            end else if (it.in_byte < CH_SPACE) begin
                fail_result(ST_CTRL);
            end else if (it.in_byte == CH_BSLASH) begin
                dec_mode = MODE_ESC;
                hex_cnt  = '0;
                code_acc = '0;
            end else begin
                push_result(it.in_byte, ST_DATA, 1'b1);
            end
        end
    endfunction

    // ------------------------------------------------------- driver and monitor

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            src_valid <= 1'b0;
            src_item  <= '0;
        end else begin
            if (src_valid && !src_stall)
                predict_unescape(src_item);
            if (!src_valid || !src_stall) begin
                if (src_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    src_item  <= src_backlog.pop_front();
                    src_valid <= 1'b1;
                end else begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTED)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n) begin
        res_item_t want;
        if (!rst_n) begin
            res_stall <= 1'b0;
        end else begin
            if (res_valid && !res_stall) begin
                if (pending_results.size() == 0) begin
                    report($sformatf("unexpected result byte %h status %0d last %b",
                                     res_item.out_byte, res_item.status, res_item.last));
                end else begin
                    want = pending_results.pop_front();
                    if (res_item.out_byte !== want.out_byte
                        || res_item.status !== want.status
                        || res_item.last !== want.last)
                        report($sformatf("got byte %h status %0d last %b, want %h %0d %b",
                                         res_item.out_byte, res_item.status, res_item.last,
                                         want.out_byte, want.status, want.last));
                end
            end
            res_stall <= ($urandom_range(0, 99) < res_stall_pct);
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic add_src(input logic [7:0] b, input logic e);
        src_item_t it;
        it.in_byte    = b;
        it.source_end = e;
        src_backlog.insert(src_backlog.size(), it);
        items_added++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function automatic logic is_escape_letter(input logic [7:0] c);
        case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic add_hex_digits(input logic [15:0] cp, input int count);
        for (int i = 3; i > 3 - count; i--)
            add_src(hex_char(cp[4*i +: 4], 1'($urandom_range(0, 1))), 1'b0);
    endtask

    task automatic add_unicode(input logic [15:0] cp);
        add_src(CH_BSLASH, 1'b0);
        add_src(CH_U, 1'b0);
        add_hex_digits(cp, 4);
    endtask

    function automatic logic [15:0] pick_code();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 6))
                    0: return 16'h0000;
                    1: return 16'h007F;
                    2: return 16'h0080;
                    3: return 16'h07FF;
                    4: return 16'h0800;
                    5: return 16'hD800;
                    default: return 16'hFFFF;
                endcase
            end
            1, 2, 3: return 16'($urandom_range(0, 16'h007F));
            4, 5, 6: return 16'($urandom_range(16'h0080, 16'h07FF));
            default: return 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
    endfunction

    task automatic add_short_escape();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0: c = CH_QUOTE;
            1: c = CH_BSLASH;
            2: c = CH_SLASH;
            3: c = CH_B;
            4: c = CH_F;
            5: c = CH_N;
            6: c = CH_R;
            default: c = CH_T;
        endcase
        add_src(CH_BSLASH, 1'b0);
        add_src(c, 1'b0);
    endtask

    // broken sequences and stray bytes
    task automatic add_noise();
        logic [7:0] c;
        case ($urandom_range(0, 4))
            0: add_src(8'($urandom_range(0, 8'h1F)), 1'b0);
            1:
            begin
                do c = 8'($urandom_range(0, 255)); while (is_escape_letter(c));
                add_src(CH_BSLASH, 1'b0);
                add_src(c, 1'b0);
            end
            2:
            begin
                do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) != 5'h10);
                add_src(CH_BSLASH, 1'b0);
                add_src(CH_U, 1'b0);
                add_hex_digits(16'($urandom), $urandom_range(0, 3));
                add_src(c, 1'b0);
            end
            3:
            begin
                add_src(CH_BSLASH, 1'b0);
                if ($urandom_range(0, 1)) begin
                    add_src(CH_U, 1'b0);
                    add_hex_digits(16'($urandom), $urandom_range(0, 3));
                end
                add_src(8'($urandom_range(0, 255)), 1'b1);
            end
            default: add_src(8'($urandom_range(0, 255)), 1'($urandom_range(0, 9) == 0));
        endcase
    endtask

    task automatic add_string();
        int         n;
        int         r;
        logic [7:0] c;
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                do c = 8'($urandom_range(CH_SPACE, 255));
                while (c == CH_QUOTE || c == CH_BSLASH);
                add_src(c, 1'b0);
            end else if (r < 75) begin
                add_short_escape();
            end else begin
                add_unicode(pick_code());
            end
        end
        r = $urandom_range(0, 99);
        if (r < 82)
            add_src(CH_QUOTE, 1'b0);
        else if (r < 90)
            add_src(8'($urandom_range(0, 255)), 1'b1);
        else
            add_noise();
    endtask

    task automatic drain();
        do @(negedge clk);
        while (src_backlog.size() != 0 || src_valid || pending_results.size() != 0);
    endtask

    task automatic run_phase(input int send_pct, input int stall_pct);
        int  start;
        logic paused;
        send_idle_pct = send_pct;
        res_stall_pct = stall_pct;
        start  = items_added;
        paused = 1'b0;
        while (items_added - start < PHASE_ITEMS) begin
            add_string();
            // sender holds off mid-phase until everything is out
            if (!paused && items_added - start >= PHASE_ITEMS / 2) begin
                drain();
                paused = 1'b1;
            end
        end
        drain();
    endtask

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // body byte extremes, control bytes and a closing quote
        add_src(CH_SPACE, 1'b0);
        add_src(8'hFF, 1'b0);
        add_src(8'h7F, 1'b0);
        add_src(8'h00, 1'b0);
        add_src(8'h1F, 1'b0);
        add_src(CH_QUOTE, 1'b0);
        // bad escape letter
        add_src(CH_BSLASH, 1'b0);
        add_src(8'h71, 1'b0);
        // two-byte and surrogate three-byte codes
        add_unicode(16'h00E9);
        add_unicode(16'hD83D);
        // bad hex digit after one good one
        add_src(CH_BSLASH, 1'b0);
        add_src(CH_U, 1'b0);
        add_src(8'h31, 1'b0);
        add_src(8'h47, 1'b0);
        // source end in body, then inside an escape
        add_src(8'hA5, 1'b1);
        add_src(CH_BSLASH, 1'b0);
        add_src(8'h5A, 1'b1);
        drain();

        run_phase(0, 0);
        run_phase(58, 0);
        run_phase(0, 58);
        run_phase(8, 8);

        repeat (20) @(negedge clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/jsu_pkg.sv
rtl/core/jsu_decode.sv
rtl/core/json_string_unescape_utf8.sv
verif/tb_json_string_unescape_utf8.sv
